// File: rtl/core/grd_pkg.sv
package grd_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned DZ_W    = 15;
  localparam logic [DZ_W-1:0] DZ_RESET = 15'd6553;

  typedef struct packed {
    logic signed [FIELD_W-1:0] left_x;
    logic signed [FIELD_W-1:0] left_y;
    logic signed [FIELD_W-1:0] right_x;
    logic signed [FIELD_W-1:0] right_y;
    logic signed [FIELD_W-1:0] left_trigger;
    logic signed [FIELD_W-1:0] right_trigger;
  } in_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] move_x;
    logic signed [FIELD_W-1:0] move_y;
    logic signed [FIELD_W-1:0] look_x;
    logic signed [FIELD_W-1:0] look_y;
    logic [DZ_W-1:0]           brake;
    logic [DZ_W-1:0]           throttle;
  } out_req_t;

  // pipeline control, shared by all lanes
  typedef struct packed {
    logic advance;
    logic vld;
  } lane_ctl_t;

endpackage

// File: rtl/core/grd_if.sv
interface grd_in_if;
  logic              valid;
  logic              ready;
  grd_pkg::in_req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface grd_out_if;
  logic              valid;
  logic              ready;
  grd_pkg::out_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/grd_lane.sv
// One stick: pipelined square root then two pipelined dividers.
module grd_lane #(
  parameter int unsigned AXIS_BITS = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [grd_pkg::FIELD_W-1:0]      x_raw,
  input  logic [grd_pkg::FIELD_W-1:0]      y_raw,
  input  logic [grd_pkg::DZ_W-1:0]         dz,
  output logic signed [grd_pkg::FIELD_W-1:0] ox,
  output logic signed [grd_pkg::FIELD_W-1:0] oy
);
  localparam int unsigned AB   = AXIS_BITS;
  localparam int unsigned SQW  = 2*AB;          // sum of squares
  localparam int unsigned RW   = AB;            // root width
  localparam int unsigned MW   = AB;            // magnitude width
  localparam int unsigned NUMW = MW + 2*(AB-1); // mag*span*FS
  localparam int unsigned DENW = RW + AB - 1;   // len*room
  localparam int unsigned QW   = NUMW;
  localparam logic [AB-1:0] FS = {1'b0, {(AB-1){1'b1}}};
  localparam int unsigned SQ_ST = RW;
  localparam int unsigned DV_ST = QW;

  // ---- stage 0: squares
  logic signed [AB-1:0] xs, ys;
  assign xs = x_raw[AB-1:0];
  assign ys = y_raw[AB-1:0];

  // sign-extended to full square width so the products keep every bit
  logic signed [SQW-1:0] xw, yw;
  assign xw = SQW'(xs);
  assign yw = SQW'(ys);

  logic [SQW-1:0] sq_r;
  logic [MW-1:0]  mx_r, my_r;
  logic           nx_r, ny_r;
  logic [grd_pkg::DZ_W-1:0] dz0_r;
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= $unsigned(xw*xw) + $unsigned(yw*yw);
      mx_r  <= xs[AB-1] ? MW'(-xs) : MW'(xs);
      my_r  <= ys[AB-1] ? MW'(-ys) : MW'(ys);
      nx_r  <= xs[AB-1];
      ny_r  <= ys[AB-1];
      dz0_r <= dz;
    end
  end

  // ---- root: one result bit per stage, by trial-square compare
  logic [SQW-1:0] rem_r [SQ_ST+1];
  logic [RW-1:0]  rt_r  [SQ_ST+1];
  logic [MW-1:0]  sx_r  [SQ_ST+1];
  logic [MW-1:0]  sy_r  [SQ_ST+1];
  logic           snx_r [SQ_ST+1];
  logic           sny_r [SQ_ST+1];
  logic [grd_pkg::DZ_W-1:0] sdz_r [SQ_ST+1];
  always_comb begin
    rem_r[0] = sq_r; rt_r[0] = '0; sx_r[0] = mx_r; sy_r[0] = my_r;
    snx_r[0] = nx_r; sny_r[0] = ny_r; sdz_r[0] = dz0_r;
  end
  for (genvar i = 0; i < SQ_ST; i++) begin : g_sq
    localparam int unsigned B = SQ_ST-1-i;
    logic [RW-1:0]  trial;
    logic [SQW-1:0] tsq;
    assign trial = rt_r[i] | (RW'(1) << B);
    assign tsq   = SQW'(trial) * SQW'(trial);
    logic [SQW-1:0] rem_q;
    logic [RW-1:0]  rt_q;
    logic [MW-1:0]  sx_q, sy_q;
    logic           snx_q, sny_q;
    logic [grd_pkg::DZ_W-1:0] sdz_q;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= rem_r[i];
        rt_q  <= (tsq <= rem_r[i]) ? trial : rt_r[i];
        sx_q <= sx_r[i]; sy_q <= sy_r[i];
        snx_q <= snx_r[i]; sny_q <= sny_r[i]; sdz_q <= sdz_r[i];
      end
    end
    always_comb begin
      rem_r[i+1] = rem_q; rt_r[i+1] = rt_q; sx_r[i+1] = sx_q; sy_r[i+1] = sy_q;
      snx_r[i+1] = snx_q; sny_r[i+1] = sny_q; sdz_r[i+1] = sdz_q;
    end
  end

  // ---- span/room stage
  logic [RW-1:0] len;
  logic [AB-1:0] cap, dze;
  logic          zero_c;
  assign len = rt_r[SQ_ST];
  assign cap = (len > RW'(FS)) ? FS : AB'(len);
  assign dze = AB'(sdz_r[SQ_ST]);
  // full-width deadzone compare against full scale
  assign zero_c = (sdz_r[SQ_ST] >= grd_pkg::DZ_W'(FS)) || (cap < dze) || (len == '0);

  logic [AB-1:0] span_r, room_r;
  logic [RW-1:0] len_r;
  logic [MW-1:0] ax_r, ay_r;
  logic          anx_r, any_r, az_r;
  always_ff @(posedge clk) begin
    if (en) begin
      span_r <= cap - dze;
      room_r <= FS - dze;
      len_r  <= len;
      ax_r <= sx_r[SQ_ST]; ay_r <= sy_r[SQ_ST];
      anx_r <= snx_r[SQ_ST]; any_r <= sny_r[SQ_ST]; az_r <= zero_c;
    end
  end

  // ---- products (each one multiply, registered)
  logic [2*AB-1:0] psx_r, psy_r;
  logic [DENW-1:0] den_r;
  logic            bnx_r, bny_r, bz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      psx_r <= (2*AB)'(ax_r) * (2*AB)'(span_r);
      psy_r <= (2*AB)'(ay_r) * (2*AB)'(span_r);
      den_r <= DENW'(len_r) * DENW'(room_r);
      bnx_r <= anx_r; bny_r <= any_r; bz_r <= az_r;
    end
  end
  logic [NUMW-1:0] numx_r, numy_r;
  logic [DENW-1:0] den2_r;
  logic            cnx_r, cny_r, cz_r;
  always_ff @(posedge clk) begin
    if (en) begin
      // times FS = shift minus self
      numx_r <= (NUMW'(psx_r) << (AB-1)) - NUMW'(psx_r);
      numy_r <= (NUMW'(psy_r) << (AB-1)) - NUMW'(psy_r);
      den2_r <= den_r; cnx_r <= bnx_r; cny_r <= bny_r; cz_r <= bz_r;
    end
  end

  // ---- two dividers, one quotient bit per stage
  localparam int unsigned RMW = DENW + 1;
  logic [NUMW-1:0] dnx [DV_ST+1], dny [DV_ST+1];
  logic [RMW-1:0]  drx [DV_ST+1], dry [DV_ST+1];
  logic [DENW-1:0] dd  [DV_ST+1];
  logic            dnxs [DV_ST+1], dnys [DV_ST+1], dz_s [DV_ST+1];
  always_comb begin
    dnx[0] = numx_r; dny[0] = numy_r; drx[0] = '0; dry[0] = '0; dd[0] = den2_r;
    dnxs[0] = cnx_r; dnys[0] = cny_r; dz_s[0] = cz_r;
  end
  for (genvar i = 0; i < DV_ST; i++) begin : g_dv
    logic [RMW-1:0] tx, ty;
    assign tx = {drx[i][RMW-2:0], dnx[i][NUMW-1]};
    assign ty = {dry[i][RMW-2:0], dny[i][NUMW-1]};
    logic gx, gy;
    assign gx = tx >= RMW'(dd[i]);
    assign gy = ty >= RMW'(dd[i]);
    logic [NUMW-1:0] nx_q, ny_q;
    logic [RMW-1:0]  rx_q, ry_q;
    logic [DENW-1:0] d_q;
    logic            sx_q2, sy_q2, z_q;
    always_ff @(posedge clk) begin
      if (en) begin
        nx_q <= {dnx[i][NUMW-2:0], gx};
        ny_q <= {dny[i][NUMW-2:0], gy};
        rx_q <= gx ? tx - RMW'(dd[i]) : tx;
        ry_q <= gy ? ty - RMW'(dd[i]) : ty;
        d_q <= dd[i]; sx_q2 <= dnxs[i]; sy_q2 <= dnys[i]; z_q <= dz_s[i];
      end
    end
    always_comb begin
      dnx[i+1] = nx_q; dny[i+1] = ny_q; drx[i+1] = rx_q; dry[i+1] = ry_q;
      dd[i+1] = d_q; dnxs[i+1] = sx_q2; dnys[i+1] = sy_q2; dz_s[i+1] = z_q;
    end
  end

  // ---- saturate and sign
  logic [QW-1:0] qx, qy;
  logic [AB-1:0] sx, sy;
  assign qx = dnx[DV_ST];
  assign qy = dny[DV_ST];
  assign sx = (qx > QW'(FS)) ? FS : AB'(qx);
  assign sy = (qy > QW'(FS)) ? FS : AB'(qy);
  logic [AB-1:0] vx, vy;
  assign vx = dz_s[DV_ST] ? '0 : (dnxs[DV_ST] ? AB'(-sx) : sx);
  assign vy = dz_s[DV_ST] ? '0 : (dnys[DV_ST] ? AB'(-sy) : sy);
  assign ox = grd_pkg::FIELD_W'($signed(vx));
  assign oy = grd_pkg::FIELD_W'($signed(vy));
endmodule

// File: rtl/core/grd_trig.sv
// Trigger clamp, delayed to line up with the stick lanes.
module grd_trig #(
  parameter int unsigned AXIS_BITS = 16,
  parameter int unsigned DEPTH     = 4
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [grd_pkg::FIELD_W-1:0] t_raw,
  output logic [grd_pkg::DZ_W-1:0]    t_out
);
  localparam logic [AXIS_BITS-1:0] FS = {1'b0, {(AXIS_BITS-1){1'b1}}};
  logic [AXIS_BITS-1:0] t;
  assign t = t_raw[AXIS_BITS-1:0];
  logic [grd_pkg::DZ_W-1:0] dl_r [DEPTH];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= t[AXIS_BITS-1] ? '0 : grd_pkg::DZ_W'(t & FS);
      for (int i = 1; i < DEPTH; i++) dl_r[i] <= dl_r[i-1];
    end
  end
  assign t_out = dl_r[DEPTH-1];
endmodule

// File: rtl/core/gamepad_radial_deadzone_unit.sv
// Channel | dir | payload                                 | handshake
// in      | in  | left/right x,y, left/right trigger      | valid/ready
// out     | out | move_x/y, look_x/y, brake, throttle      | valid/ready
// cfg     | in  | deadzone (15 bits)                       | cfg_we only
//
// One request per cycle sustained while the sink keeps taking results.
// Depth is set by the bit-per-stage square root and the quotient-per-stage dividers.
// The whole pipeline advances together and freezes only when the last
// stage holds a result the sink has not taken. rst_n (sync) clears the
// valid bits and restores deadzone to 6553.
module gamepad_radial_deadzone_unit #(
  parameter int unsigned AXIS_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  grd_in_if.sink                   in_ch,
  grd_out_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic [grd_pkg::DZ_W-1:0] cfg_wdata
);
  // stages: squares, AXIS_BITS root, span, 2 product, 3*AXIS_BITS-2 divide
  localparam int unsigned LAT = 1 + AXIS_BITS + 1 + 2 + (3*AXIS_BITS - 2);

  logic [grd_pkg::DZ_W-1:0] dz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) dz_r <= grd_pkg::DZ_RESET;
    else if (cfg_we) dz_r <= cfg_wdata;
  end

  // shift-register of valid flags; whole pipe stalls on full tail
  grd_pkg::lane_ctl_t ctl;
  logic [LAT-1:0] vld_r;
  assign ctl.vld     = vld_r[LAT-1];
  assign ctl.advance = !ctl.vld || out_ch.ready;
  assign in_ch.ready = ctl.advance;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (ctl.advance) vld_r <= {vld_r[LAT-2:0], in_ch.valid};
  end

  grd_lane #(.AXIS_BITS(AXIS_BITS)) u_left (
    .clk(clk), .en(ctl.advance),
    .x_raw(in_ch.data.left_x), .y_raw(in_ch.data.left_y), .dz(dz_r),
    .ox(out_ch.data.move_x), .oy(out_ch.data.move_y));
  grd_lane #(.AXIS_BITS(AXIS_BITS)) u_right (
    .clk(clk), .en(ctl.advance),
    .x_raw(in_ch.data.right_x), .y_raw(in_ch.data.right_y), .dz(dz_r),
    .ox(out_ch.data.look_x), .oy(out_ch.data.look_y));
  grd_trig #(.AXIS_BITS(AXIS_BITS), .DEPTH(LAT)) u_lt (
    .clk(clk), .en(ctl.advance), .t_raw(in_ch.data.left_trigger),
    .t_out(out_ch.data.brake));
  grd_trig #(.AXIS_BITS(AXIS_BITS), .DEPTH(LAT)) u_rt (
    .clk(clk), .en(ctl.advance), .t_raw(in_ch.data.right_trigger),
    .t_out(out_ch.data.throttle));

  assign out_ch.valid = ctl.vld;

`ifndef SYNTHESIS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input taken during stall");
  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.brake <= grd_pkg::DZ_W'(2**(AXIS_BITS-1)-1))
    else $error("brake out of range");
`endif
endmodule
